### hdl/heading_pid_turn_controller_core_assert.svh
// ----------------------------------------------------------------------------
// heading pid turn controller assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HEADING_PID_TURN_CONTROLLER_CORE_ASSERT_SVH
`define HEADING_PID_TURN_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition in this cycle implies consequence in the same cycle
`define HPTC_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("hptc check failed");

// condition in this cycle implies consequence in the next cycle
`define HPTC_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("hptc check failed");

`else

`define HPTC_ASSERT_NOW(label, cond, cons)
`define HPTC_ASSERT_NEXT(label, cond, cons)

`endif

`endif

### hdl/hptc_pkg.sv
// ----------------------------------------------------------------------------
// hptc_pkg
// widths, reset values and register indexes of the heading pid controller
// ----------------------------------------------------------------------------
package hptc_pkg;

    // default parameter values
    localparam int HPTC_ANGLE_FRAC_BITS = 8;
    localparam int HPTC_POWER_WIDTH     = 24;

    // fixed field widths
    localparam int HEADING_W   = 17;
    localparam int GAIN_W      = 16;
    localparam int CAP_W       = 24;
    localparam int ERR_W       = 17;
    localparam int ESUM_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // register reset values
    localparam logic [HEADING_W-1:0]    TARGET_RESET = '0;
    localparam logic [GAIN_W-1:0]       GAIN_P_RESET = 16'd563;
    localparam logic [GAIN_W-1:0]       GAIN_I_RESET = '0;
    localparam logic [GAIN_W-1:0]       GAIN_D_RESET = '0;
    localparam logic signed [CAP_W-1:0] CAP_RESET    = 24'sh7FFFFF;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_HEADING = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_CAP   = 3'd4
    } cfg_index_t;

endpackage

### hdl/heading_pid_turn_controller_core.sv
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_core
// heading pid with wrapped error, integral zone, capped i term and done flag
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | heading, first_sample
//  out     | out_valid / out_stall | drive_power, wrapped_error, done_res
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  four register stages: input, error and integral, products, result;
//  out_valid marks a loaded result; one result per cycle while out_stall is low
//  the integral and previous error update as a request leaves the input stage
//  each stage advances when empty or when the stage after it advances,
//  so bubbles are filled while a finished result waits on out_stall
//  reset empties the pipeline and loads the register defaults
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_core
    import hptc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = HPTC_ANGLE_FRAC_BITS,
    parameter int POWER_WIDTH     = HPTC_POWER_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [HEADING_W-1:0]          heading,
    input  logic                          first_sample,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [POWER_WIDTH-1:0] drive_power,
    output logic signed [ERR_W-1:0]       wrapped_error,
    output logic                          done_res,

    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    // derived widths and angle constants
    localparam int DIFF_W = ((9 + ANGLE_FRAC_BITS > HEADING_W) ?
                             9 + ANGLE_FRAC_BITS : HEADING_W) + 2;
    localparam int DERIV_W = ERR_W + 1;
    localparam int PP_W    = GAIN_W + 1 + ERR_W;
    localparam int PI_W    = GAIN_W + 1 + ESUM_W;
    localparam int PD_W    = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W   = PI_W + 4;

    localparam logic signed [DIFF_W-1:0] ANG_180 = DIFF_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] ANG_360 = DIFF_W'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] ANG_30  = DIFF_W'(30 << ANGLE_FRAC_BITS);
    localparam int                       TOL_INT = ((7 << ANGLE_FRAC_BITS) + 5) / 10;
    localparam logic signed [DIFF_W-1:0] ANG_TOL = DIFF_W'(TOL_INT);
    localparam logic signed [DIFF_W-1:0] ERR_MAX = DIFF_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] ERR_MIN = -ERR_MAX - DIFF_W'(1);

    localparam logic signed [ESUM_W:0] ESUM_MAX = (ESUM_W+1)'((1 << (ESUM_W - 1)) - 1);
    localparam logic signed [ESUM_W:0] ESUM_MIN = -ESUM_MAX - (ESUM_W+1)'(1);

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (ANGLE_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] PW_MAX   =
        SUM_W'((64'd1 << (POWER_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] PW_MIN   = -PW_MAX - SUM_W'(1);

    localparam logic signed [ERR_W-1:0] TOL_ERR = ERR_W'(TOL_INT);

    // configuration registers
    logic [HEADING_W-1:0]    target_heading_reg;
    logic [GAIN_W-1:0]       gain_p_reg;
    logic [GAIN_W-1:0]       gain_i_reg;
    logic [GAIN_W-1:0]       gain_d_reg;
    logic signed [CAP_W-1:0] integral_cap_reg;

    // controller state
    logic signed [ESUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]  previous_error_reg;

    // pipeline valid bits and stage enables
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s0_en, s1_en, s2_en, out_en;

    // stage 0: input request
    logic [HEADING_W-1:0] s0_heading_reg;
    logic                 s0_first_reg;

    // stage 1: error, integral, derivative
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [ESUM_W-1:0]  s1_esum_reg;
    logic signed [DERIV_W-1:0] s1_deriv_reg;
    logic                      s1_done_reg;

    // stage 2: products
    logic signed [PP_W-1:0]  s2_prod_p_reg;
    logic signed [PI_W-1:0]  s2_prod_i_reg;
    logic signed [PD_W-1:0]  s2_prod_d_reg;
    logic signed [ERR_W-1:0] s2_err_reg;
    logic                    s2_done_reg;

    // result register
    logic signed [POWER_WIDTH-1:0] drive_power_reg;
    logic signed [ERR_W-1:0]       wrapped_error_reg;
    logic                          done_reg;

    // stage 1 combinational signals
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_wrapped;
    logic signed [DIFF_W-1:0]  diff_sat;
    logic signed [DIFF_W-1:0]  abs_err;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [ESUM_W-1:0]  esum_base;
    logic signed [ESUM_W:0]    esum_wide;
    logic signed [ESUM_W-1:0]  esum_next;
    logic signed [ERR_W-1:0]   prev_used;
    logic signed [DERIV_W-1:0] deriv_next;
    logic                      done_next;

    // stage 2 combinational signals
    logic signed [PP_W-1:0] prod_p_next;
    logic signed [PI_W-1:0] prod_i_next;
    logic signed [PD_W-1:0] prod_d_next;

    // result stage combinational signals
    logic signed [SUM_W-1:0]       p_term;
    logic signed [SUM_W-1:0]       i_round;
    logic signed [SUM_W-1:0]       i_term;
    logic signed [SUM_W-1:0]       d_term;
    logic signed [SUM_W-1:0]       cap_ext;
    logic signed [SUM_W-1:0]       power_sum;
    logic signed [POWER_WIDTH-1:0] power_next;

    // check helpers
    logic s1_load;
    logic pipe_full;
    logic err_in_tol;

    // handshake: a stage moves when it is empty or its successor moves
    assign out_en   = !out_valid_reg || !out_stall;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s0_en    = !s0_valid_reg || s1_en;
    assign in_stall = !s0_en;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_heading_reg <= TARGET_RESET;
            gain_p_reg         <= GAIN_P_RESET;
            gain_i_reg         <= GAIN_I_RESET;
            gain_d_reg         <= GAIN_D_RESET;
            integral_cap_reg   <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_HEADING: target_heading_reg <= cfg_data[HEADING_W-1:0];
                REG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_CAP:   integral_cap_reg   <= signed'(cfg_data[CAP_W-1:0]);
                default:            ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_en)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_en)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_valid && s0_en)
        begin
            s0_heading_reg <= heading;
            s0_first_reg   <= first_sample;
        end
    end

    // wrapped and saturated error
    always_comb
    begin
        diff = DIFF_W'(signed'({1'b0, target_heading_reg}))
             - DIFF_W'(signed'({1'b0, s0_heading_reg}));
        if (diff > ANG_180)
        begin
            diff_wrapped = diff - ANG_360;
        end
        else if (diff < -ANG_180)
        begin
            diff_wrapped = diff + ANG_360;
        end
        else
        begin
            diff_wrapped = diff;
        end
        if (diff_wrapped > ERR_MAX)
        begin
            diff_sat = ERR_MAX;
        end
        else if (diff_wrapped < ERR_MIN)
        begin
            diff_sat = ERR_MIN;
        end
        else
        begin
            diff_sat = diff_wrapped;
        end
        err_next  = diff_sat[ERR_W-1:0];
        abs_err   = (diff_sat < 0) ? -diff_sat : diff_sat;
        done_next = (abs_err <= ANG_TOL);
    end

    // integral inside the zone, derivative against the previous error
    always_comb
    begin
        esum_base = s0_first_reg ? '0 : error_sum_reg;
        prev_used = s0_first_reg ? err_next : previous_error_reg;
        esum_wide = (ESUM_W+1)'(esum_base) + (ESUM_W+1)'(err_next);
        if ((abs_err < ANG_30) && (err_next != '0))
        begin
            if (esum_wide > ESUM_MAX)
            begin
                esum_next = ESUM_MAX[ESUM_W-1:0];
            end
            else if (esum_wide < ESUM_MIN)
            begin
                esum_next = ESUM_MIN[ESUM_W-1:0];
            end
            else
            begin
                esum_next = esum_wide[ESUM_W-1:0];
            end
        end
        else
        begin
            esum_next = '0;
        end
        deriv_next = DERIV_W'(err_next) - DERIV_W'(prev_used);
    end

    // controller state advances as a request enters stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
        end
        else if (s0_valid_reg && s1_en)
        begin
            error_sum_reg      <= esum_next;
            previous_error_reg <= err_next;
        end
    end

    // stage 1 register
    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && s1_en)
        begin
            s1_err_reg   <= err_next;
            s1_esum_reg  <= esum_next;
            s1_deriv_reg <= deriv_next;
            s1_done_reg  <= done_next;
        end
    end

    // gain products
    assign prod_p_next = PP_W'(signed'({1'b0, gain_p_reg})) * PP_W'(s1_err_reg);
    assign prod_i_next = PI_W'(signed'({1'b0, gain_i_reg})) * PI_W'(s1_esum_reg);
    assign prod_d_next = PD_W'(signed'({1'b0, gain_d_reg})) * PD_W'(s1_deriv_reg);

    // stage 2 register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_en)
        begin
            s2_prod_p_reg <= prod_p_next;
            s2_prod_i_reg <= prod_i_next;
            s2_prod_d_reg <= prod_d_next;
            s2_err_reg    <= s1_err_reg;
            s2_done_reg   <= s1_done_reg;
        end
    end

    // round half up, cap the i term, sum and saturate
    always_comb
    begin
        p_term  = (SUM_W'(s2_prod_p_reg) + RND_HALF) >>> ANGLE_FRAC_BITS;
        i_round = (SUM_W'(s2_prod_i_reg) + RND_HALF) >>> ANGLE_FRAC_BITS;
        d_term  = (SUM_W'(s2_prod_d_reg) + RND_HALF) >>> ANGLE_FRAC_BITS;
        cap_ext = SUM_W'(integral_cap_reg);
        i_term  = (i_round > cap_ext) ? cap_ext : i_round;
        power_sum = p_term + i_term + d_term;
        if (power_sum > PW_MAX)
        begin
            power_next = PW_MAX[POWER_WIDTH-1:0];
        end
        else if (power_sum < PW_MIN)
        begin
            power_next = PW_MIN[POWER_WIDTH-1:0];
        end
        else
        begin
            power_next = power_sum[POWER_WIDTH-1:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_en)
        begin
            drive_power_reg   <= power_next;
            wrapped_error_reg <= s2_err_reg;
            done_reg          <= s2_done_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_power   = drive_power_reg;
    assign wrapped_error = wrapped_error_reg;
    assign done_res      = done_reg;

    // checks
    assign s1_load    = s0_valid_reg && s1_en;
    assign pipe_full  = s0_valid_reg && s1_valid_reg && s2_valid_reg && out_valid_reg;
    assign err_in_tol = (wrapped_error_reg <= TOL_ERR) && (wrapped_error_reg >= -TOL_ERR);

`include "heading_pid_turn_controller_core_assert.svh"

    `HPTC_ASSERT_NEXT(a_first_zero_deriv, s1_load && s0_first_reg, s1_deriv_reg == '0)
    `HPTC_ASSERT_NEXT(a_zero_err_clears_sum, s1_load && (err_next == '0), error_sum_reg == '0)
    `HPTC_ASSERT_NOW(a_stall_only_when_full, in_stall, pipe_full)
    `HPTC_ASSERT_NOW(a_done_within_tol, out_valid_reg && done_reg, err_in_tol)

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: heading pid turn controller testbench
// drives heading samples through the valid/stall request channel and checks
// every result against an in-bench pid predictor. covers angle wrap, the
// integral zone, caps, saturation, unused register writes, back-pressure and
// randomized turns under several gain and target settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hptc_pkg::*;

    localparam int FRAC    = HPTC_ANGLE_FRAC_BITS;
    localparam int POWER_W = HPTC_POWER_WIDTH;

    // angle constants in 1/2^FRAC degree
    localparam longint HALF_TURN = longint'(180) << FRAC;
    localparam longint FULL_TURN = longint'(360) << FRAC;
    localparam longint I_ZONE    = longint'(30) << FRAC;
    localparam longint DONE_TOL  = ((longint'(7) << FRAC) + 5) / 10;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_REQUESTS  = 80;
    localparam int ACC_RUN_LEN     = 150;

    typedef struct {
        logic signed [POWER_W-1:0] power;
        logic signed [ERR_W-1:0]   err;
        logic                      done;
    } turn_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [HEADING_W-1:0]      heading;
    logic                      first_sample;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [POWER_W-1:0] drive_power;
    logic signed [ERR_W-1:0]   wrapped_error;
    logic                      done_res;
    logic                      cfg_write;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // predictor copy of the registers and the controller state
    logic [HEADING_W-1:0]    aim_heading = TARGET_RESET;
    logic [GAIN_W-1:0]       kp          = GAIN_P_RESET;
    logic [GAIN_W-1:0]       ki          = GAIN_I_RESET;
    logic [GAIN_W-1:0]       kd          = GAIN_D_RESET;
    logic signed [CAP_W-1:0] i_limit     = CAP_RESET;
    longint                  error_acc   = 0;
    longint                  last_error  = 0;

    turn_result_t turn_results_q[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    bit           sender_gaps    = 1'b1;
    bit           receiver_gaps  = 1'b1;
    bit           hold_request   = 1'b0;

    heading_pid_turn_controller_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .heading       (heading),
        .first_sample  (first_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_power   (drive_power),
        .wrapped_error (wrapped_error),
        .done_res      (done_res),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // gain times value, scaled down with round half up
    function automatic longint scale_gain(input longint v);
        return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic turn_result_t predict_turn(input logic [HEADING_W-1:0] hdg,
                                                  input logic first);
        turn_result_t r;
        longint err;
        longint mag;
        longint slope;
        longint p_term;
        longint i_term;
        longint d_term;
        // shortest error, one full-turn correction only
        err = longint'(aim_heading) - longint'(hdg);
        if (err > HALF_TURN)
            err -= FULL_TURN;
        else if (err < -HALF_TURN)
            err += FULL_TURN;
        err = clamp_signed(err, ERR_W);
        mag = (err < 0) ? -err : err;
        // a new turn clears the integral and zeroes the derivative
        if (first)
        begin
            error_acc  = 0;
            last_error = err;
        end
        slope = err - last_error;
        // integrate only inside the zone, excluding zero error
        if (mag < I_ZONE && err != 0)
            error_acc = clamp_signed(error_acc + err, ESUM_W);
        else
            error_acc = 0;
        p_term = scale_gain(longint'(kp) * err);
        i_term = scale_gain(longint'(ki) * error_acc);
        if (i_term > longint'(i_limit))
            i_term = longint'(i_limit);
        d_term = scale_gain(longint'(kd) * slope);
        last_error = err;
        r.power = POWER_W'(clamp_signed(p_term + i_term + d_term, POWER_W));
        r.err   = ERR_W'(err);
        r.done  = (mag <= DONE_TOL);
        return r;
    endfunction

    // heading that gives the wanted error against the current target
    function automatic logic [HEADING_W-1:0] heading_at_error(input longint e);
        longint h;
        h = (longint'(aim_heading) - e) % FULL_TURN;
        if (h < 0)
            h += FULL_TURN;
        return h[HEADING_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string field, input longint want_v,
                                 input longint got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
    endtask

    always @(posedge clk)
    begin : result_check
        turn_result_t want;
        if (rst_n)
        begin
            // accepted result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (turn_results_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with no request pending, power %0d",
                                 $time, drive_power);
                end
                else
                begin
                    want = turn_results_q.pop_front();
                    if (drive_power !== want.power)
                        flag_mismatch("drive_power", want.power, drive_power);
                    if (wrapped_error !== want.err)
                        flag_mismatch("wrapped_error", want.err, wrapped_error);
                    if (done_res !== want.done)
                        flag_mismatch("done_res", want.done, done_res);
                end
            end
            // accepted request
            if (in_valid && !in_stall)
                turn_results_q.push_back(predict_turn(heading, first_sample));
            // register writes, unknown indexes are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TARGET_HEADING: aim_heading = cfg_data[HEADING_W-1:0];
                    REG_GAIN_P:         kp          = cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:         ki          = cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:         kd          = cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_CAP:   i_limit     = cfg_data[CAP_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // result side stall pattern, with an occasional long hold-off
    initial
    begin : result_sink
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall    <= 1'b1;
                hold_request = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (receiver_gaps)
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
        end
    end

    task automatic send_sample(input logic [HEADING_W-1:0] hdg, input logic first);
        int pause;
        in_valid     <= 1'b1;
        heading      <= hdg;
        first_sample <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pause = sender_gaps ? pick_gap() : 0;
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait for every pending result
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (turn_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset gains, tolerance edges and an out-of-range heading
    task automatic test_default_gains();
        send_sample(0, 1'b1);
        send_sample(179, 1'b0);
        send_sample(180, 1'b0);
        send_sample(91981, 1'b0);
        send_sample('1, 1'b0);
        send_sample(46080, 1'b0);
    endtask

    // exact half turn is kept, beyond it one full turn is taken off
    task automatic test_wrap_edges();
        wait_idle();
        write_reg(REG_TARGET_HEADING, 46080);
        send_sample(0, 1'b1);
        send_sample(92160, 1'b0);
        send_sample(92161, 1'b0);
        wait_idle();
        write_reg(REG_TARGET_HEADING, 131071);
        send_sample(0, 1'b0);
        send_sample(131071, 1'b0);
        wait_idle();
        write_reg(REG_TARGET_HEADING, 92159);
        send_sample(0, 1'b0);
    endtask

    // integral zone edges, zero error and turn restarts
    task automatic test_integral_zone();
        wait_idle();
        write_reg(REG_TARGET_HEADING, 46080);
        write_reg(REG_GAIN_P, 256);
        write_reg(REG_GAIN_I, 512);
        write_reg(REG_GAIN_D, 768);
        write_reg(REG_INTEGRAL_CAP, 24'h7FFFFF);
        send_sample(heading_at_error(I_ZONE - 1), 1'b1);
        send_sample(heading_at_error(I_ZONE - 1), 1'b0);
        send_sample(heading_at_error(I_ZONE), 1'b0);
        send_sample(heading_at_error(1 - I_ZONE), 1'b0);
        send_sample(heading_at_error(0), 1'b0);
        send_sample(heading_at_error(100), 1'b1);
        send_sample(heading_at_error(-100), 1'b0);
        send_sample(heading_at_error(-I_ZONE), 1'b0);
    endtask

    // full gains with a negative cap, then long runs that build up the sum
    task automatic test_saturation();
        int k;
        wait_idle();
        write_reg(REG_GAIN_P, 16'hFFFF);
        write_reg(REG_GAIN_I, 16'hFFFF);
        write_reg(REG_GAIN_D, 16'hFFFF);
        write_reg(REG_INTEGRAL_CAP, 24'h800000);
        send_sample(heading_at_error(HALF_TURN), 1'b1);
        send_sample(heading_at_error(-HALF_TURN), 1'b0);
        send_sample(heading_at_error(I_ZONE - 1), 1'b1);
        send_sample(heading_at_error(I_ZONE - 1), 1'b0);
        wait_idle();
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_I, 256);
        write_reg(REG_GAIN_D, 0);
        write_reg(REG_INTEGRAL_CAP, 24'h7FFFFF);
        sender_gaps = 1'b0;
        for (k = 0; k < ACC_RUN_LEN; k++)
            send_sample(heading_at_error(I_ZONE - 1), k == 0);
        for (k = 0; k < ACC_RUN_LEN; k++)
            send_sample(heading_at_error(1 - I_ZONE), k == 0);
        sender_gaps = 1'b1;
    endtask

    // writes past the last register must leave the settings alone
    task automatic test_unused_index();
        int idx;
        wait_idle();
        write_reg(REG_GAIN_P, 563);
        write_reg(REG_GAIN_I, 40);
        write_reg(REG_GAIN_D, 300);
        write_reg(REG_INTEGRAL_CAP, 2000);
        for (idx = int'(REG_INTEGRAL_CAP) + 1; idx < (1 << CFG_INDEX_W); idx++)
            write_reg(CFG_INDEX_W'(idx), '1);
        send_sample(heading_at_error(500), 1'b1);
        send_sample(heading_at_error(-300), 1'b0);
        send_sample(heading_at_error(7000), 1'b0);
    endtask

    // long result hold-off while requests keep coming
    task automatic test_backpressure();
        int k;
        wait_idle();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        while (hold_request)
            @(posedge clk);
        for (k = 0; k < 40; k++)
            send_sample(heading_at_error(longint'($urandom_range(0, 4000)) - 2000), k % 9 == 0);
        sender_gaps = 1'b1;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DATA_W'(16'hFFFF);
            2:       return CFG_DATA_W'($urandom_range(0, 1023));
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_cap();
        case ($urandom_range(0, 4))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return '0;
            3:       return CFG_DATA_W'($urandom_range(0, 20000));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_target();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CFG_DATA_W'(92159);
            2:       return CFG_DATA_W'(131071);
            3:       return CFG_DATA_W'($urandom_range(0, 92159));
            default: return CFG_DATA_W'($urandom_range(0, 131071));
        endcase
    endfunction

    // turns that close in on the target, mixed with raw samples
    task automatic test_random_turns();
        int     phase;
        int     sent;
        int     run_len;
        int     k;
        longint e;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            sender_gaps   = (phase % 3) != 1;
            receiver_gaps = (phase % 3) != 2;
            write_reg(REG_TARGET_HEADING, pick_target());
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            write_reg(REG_INTEGRAL_CAP, pick_cap());
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    run_len = $urandom_range(3, 16);
                    e = longint'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
                    for (k = 0; k < run_len; k++)
                    begin
                        send_sample(heading_at_error(e), k == 0);
                        e = e * longint'($urandom_range(2, 9)) / 10
                            + longint'($urandom_range(0, 64)) - 32;
                        if ($urandom_range(0, 7) == 0)
                            e = 0;
                    end
                    sent += run_len;
                end
                else
                begin
                    send_sample(HEADING_W'($urandom_range(0, 131071)),
                                1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        receiver_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        heading      <= '0;
        first_sample <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_gains();
        test_wrap_edges();
        test_integral_zone();
        test_saturation();
        test_unused_index();
        test_backpressure();
        test_random_turns();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/hptc_pkg.sv
hdl/heading_pid_turn_controller_core.sv
dv/tb.sv
